FILE: rtl/tts_pkg.sv
// Shared types, constants and helper functions for the trilinear texture sampler.
// No dependencies; the files that use this package refer to it by scoped names.
package tts_pkg;

  localparam int unsigned MAX_SIZE_LOG2   = 8;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned SIZE_LOG2_RESET = 8;
  localparam int unsigned LEVEL_LIMIT     = 12;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         level;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic [31:0]        texel_rgba;
    logic signed [23:0] u_coord;
    logic signed [23:0] v_coord;
    logic signed [23:0] du_dx;
    logic signed [23:0] dv_dx;
    logic signed [23:0] du_dy;
    logic signed [23:0] dv_dy;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  // width of a level number for a chain of mlog+1 levels
  function automatic int unsigned lvl_width(int unsigned mlog);
    return (mlog < 1) ? 1 : $clog2(mlog + 1);
  endfunction

  // width of a texel coordinate within level 0
  function automatic int unsigned crd_width(int unsigned mlog);
    return (mlog < 1) ? 1 : mlog;
  endfunction

  // first bank entry of level k; each bank holds a quarter of every level below the single-texel top one
  function automatic int unsigned bank_base(int unsigned k, int unsigned mlog);
    int unsigned acc;
    int unsigned res;
    acc = 0;
    res = 0;
    for (int unsigned j = 0; j <= LEVEL_LIMIT; j++) begin
      if (j == k) res = acc;
      if (j < mlog) acc = acc + (32'd1 << (2 * (mlog - 1 - j)));
    end
    return res;
  endfunction

  function automatic int unsigned bank_depth(int unsigned mlog);
    return bank_base(mlog, mlog) + 1;
  endfunction

  function automatic int unsigned job_width(int unsigned mlog, int unsigned frac);
    return 1 + lvl_width(mlog) + 8 + 32 + 2 * (4 * crd_width(mlog) + 2 * frac);
  endfunction

endpackage

FILE: rtl/trilinear_texture_sampler.sv
// Top level of the trilinear texture sampler: size register, front part,
// job queue and back part. Uses tts_pkg, tts_front, tts_queue, tts_back.
//
// Input beats carry either a texel write (mode 0) or a sample request (mode 1);
// each channel moves a beat when valid is high and stall is low. Writes to
// texels outside the current chain are dropped and give no result. A sample
// gives one output beat of four 8-bit channels.
// The size register is written on its own valid/ready channel, ready always
// high; write it only while the block is idle.
// Throughput, unless the output stalls, is one write per cycle and the same for
// samples with an integral lod; a sample with a fractional lod reads its two
// levels in turn before the queue head moves on, set by the four texel banks that
// each give one corner of one level per cycle.
// Reset clears the pipelines and queue and sets the size register to 8; texel
// memory is not cleared and must be written before it is sampled.
// While the output is stalled the back part holds, the queue fills and then
// the input stalls; the front keeps running until the queue is full.
module trilinear_texture_sampler #(
  parameter int unsigned MAX_SIZE_LOG2   = tts_pkg::MAX_SIZE_LOG2,
  parameter int unsigned COORD_FRAC_BITS = tts_pkg::COORD_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tts_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tts_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i
);

  localparam int unsigned LW = tts_pkg::lvl_width(MAX_SIZE_LOG2);
  localparam int unsigned JW = tts_pkg::job_width(MAX_SIZE_LOG2, COORD_FRAC_BITS);

  logic [3:0]    size_q;
  logic [LW-1:0] size_eff;
  logic          q_push, q_full, q_pop, q_empty;
  logic [JW-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'(tts_pkg::SIZE_LOG2_RESET);
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // saturate to the largest chain the memory holds
  assign size_eff = (32'(size_q) > MAX_SIZE_LOG2) ? LW'(MAX_SIZE_LOG2) : LW'(size_q);

  tts_front #(
    .MAX_SIZE_LOG2   (MAX_SIZE_LOG2),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .JW              (JW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .size_i     (size_eff),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_wdata)
  );

  tts_queue #(
    .WIDTH (JW),
    .DEPTH (tts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  tts_back #(
    .MAX_SIZE_LOG2   (MAX_SIZE_LOG2),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .JW              (JW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/tts_queue.sv
// Short job queue between the sampler front and back parts.
// No dependencies.
module tts_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (pop_i) rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

endmodule

FILE: rtl/tts_front.sv
// Sampler front part: takes input beats, finds the level of detail through a
// squaring log2 pipeline and forms texel jobs for the queue. Uses tts_pkg.
module tts_front #(
  parameter int unsigned MAX_SIZE_LOG2   = tts_pkg::MAX_SIZE_LOG2,
  parameter int unsigned COORD_FRAC_BITS = tts_pkg::COORD_FRAC_BITS,
  parameter int unsigned JW = tts_pkg::job_width(MAX_SIZE_LOG2, COORD_FRAC_BITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tts_pkg::in_item_t    in_data_i,
  input  logic [tts_pkg::lvl_width(MAX_SIZE_LOG2)-1:0] size_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [JW-1:0]        q_job_o
);

  localparam int unsigned M   = MAX_SIZE_LOG2;
  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned LW  = tts_pkg::lvl_width(M);
  localparam int unsigned XW  = tts_pkg::crd_width(M);
  localparam int unsigned XSW = F + XW;
  localparam int unsigned NST = 15;
  localparam int unsigned NSQ = 9;

  typedef struct packed {
    logic         mode;
    logic [3:0]   level;
    logic [7:0]   texel_x;
    logic [7:0]   texel_y;
    logic [31:0]  texel_rgba;
    logic [F-1:0] fu;
    logic [F-1:0] fv;
  } ctx_t;

  typedef struct packed {
    logic       nz;
    logic [5:0] e;
  } lg_t;

  typedef struct packed {
    logic                  is_wr;
    logic [LW-1:0]         k;
    logic [7:0]            t;
    logic [31:0]           rgba;
    logic [1:0][XW-1:0]    x0, x1, y0, y1;
    logic [1:0][F-1:0]     tx, ty;
  } job_t;

  logic              adv;
  logic [NST-1:0]    vld_q;
  ctx_t              ctx_q [NST];
  lg_t               lg_q  [NST];
  lg_t               lg_d3;
  logic signed [23:0] der_q [4];
  logic [46:0]       sq_q [4];
  logic [46:0]       sq_d [4];
  logic [47:0]       m_q, m_d, m3_q;
  logic [31:0]       mant_q [NSQ+1];
  logic [31:0]       mant_d [NSQ+1];
  logic [8:0]        bits_q [NSQ+1];
  logic [8:0]        bits_d [NSQ+1];
  logic [LW-1:0]     lo_q, lo_d;
  logic [7:0]        t_q, t_d;
  job_t              job;
  logic              keep;

  assign adv        = !(vld_q[NST-1] && q_full_i);
  assign in_stall_o = !adv;

  // squared footprint lengths
  always_comb begin
    logic [23:0] a;
    for (int j = 0; j < 4; j++) begin
      a = der_q[j][23] ? 24'(-der_q[j]) : 24'(der_q[j]);
      sq_d[j] = 47'(48'(a) * 48'(a));
    end
  end

  always_comb begin
    logic [47:0] lx, ly;
    lx  = 48'(sq_q[0]) + 48'(sq_q[1]);
    ly  = 48'(sq_q[2]) + 48'(sq_q[3]);
    m_d = (lx > ly) ? lx : ly;
  end

  // leading one of the squared length
  always_comb begin
    lg_d3.e  = '0;
    lg_d3.nz = |m_q;
    for (int i = 0; i < 48; i++) begin
      if (m_q[i]) lg_d3.e = 6'(i);
    end
  end

  // normalise to Q1.31, then one squaring per stage for each fraction bit
  always_comb begin
    logic [63:0] prod;
    logic [32:0] sq;
    if (lg_q[3].e >= 6'd31) mant_d[0] = 32'(m3_q >> (lg_q[3].e - 6'd31));
    else mant_d[0] = 32'(m3_q << (6'd31 - lg_q[3].e));
    bits_d[0] = '0;
    for (int i = 0; i < NSQ; i++) begin
      prod = 64'(mant_q[i]) * 64'(mant_q[i]);
      sq   = prod[63:31];
      if (sq[32]) begin
        mant_d[i+1] = sq[32:1];
        bits_d[i+1] = {bits_q[i][7:0], 1'b1};
      end else begin
        mant_d[i+1] = sq[31:0];
        bits_d[i+1] = {bits_q[i][7:0], 1'b0};
      end
    end
  end

  // lod in Q.8 from the Q.9 log2 of the squared length, floored at zero, capped at the top level
  always_comb begin
    logic signed [17:0] v;
    logic [16:0]        lod;
    logic [16:0]        cap;
    v = 18'({lg_q[13].e, bits_q[NSQ]}) + 18'({size_i, 10'b0}) - 18'(F * 1024);
    if (!lg_q[13].nz || v <= 0) lod = '0;
    else lod = 17'(v >>> 1);
    cap = 17'({size_i, 8'b0});
    if (lod > cap) lod = cap;
    lo_d = lod[8 +: LW];
    t_d  = lod[7:0];
  end

  // texel coordinates on both levels, or the target of a write
  always_comb begin
    logic [LW-1:0]  s;
    logic [XSW-1:0] xs, ys;
    logic [XW-1:0]  sm1, cx, cy;
    logic [3:0]     lim;
    logic           wr_ok;
    ctx_t           c;
    c   = ctx_q[NST-1];
    job = '0;
    job.is_wr = (c.mode == tts_pkg::MODE_WRITE);
    job.k     = lo_q;
    job.t     = t_q;
    job.rgba  = c.texel_rgba;
    for (int p = 0; p < 2; p++) begin
      if (p == 0) s = size_i - lo_q;
      else s = (lo_q < size_i) ? size_i - lo_q - LW'(1) : '0;
      xs  = (XSW'(c.fu) << s) - XSW'(c.fu);
      ys  = (XSW'(c.fv) << s) - XSW'(c.fv);
      sm1 = XW'((32'd1 << s) - 32'd1);
      cx  = xs[F +: XW];
      cy  = ys[F +: XW];
      job.x0[p] = cx;
      job.y0[p] = cy;
      job.x1[p] = (cx == sm1) ? cx : cx + XW'(1);
      job.y1[p] = (cy == sm1) ? cy : cy + XW'(1);
      job.tx[p] = xs[F-1:0];
      job.ty[p] = ys[F-1:0];
    end
    lim   = 4'(size_i);
    wr_ok = (c.level <= lim)
         && ({24'd0, c.texel_x} < (32'd1 << (lim - c.level)))
         && ({24'd0, c.texel_y} < (32'd1 << (lim - c.level)));
    if (job.is_wr) begin
      job.k     = LW'(c.level);
      job.x0[0] = XW'(c.texel_x);
      job.y0[0] = XW'(c.texel_y);
    end
    keep = !job.is_wr || wr_ok;
  end

  assign q_push_o = vld_q[NST-1] && !q_full_i && keep;
  assign q_job_o  = JW'(job);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0].mode       <= in_data_i.mode;
      ctx_q[0].level      <= in_data_i.level;
      ctx_q[0].texel_x    <= in_data_i.texel_x;
      ctx_q[0].texel_y    <= in_data_i.texel_y;
      ctx_q[0].texel_rgba <= in_data_i.texel_rgba;
      ctx_q[0].fu         <= in_data_i.u_coord[F-1:0];
      ctx_q[0].fv         <= in_data_i.v_coord[F-1:0];
      der_q[0] <= in_data_i.du_dx;
      der_q[1] <= in_data_i.dv_dx;
      der_q[2] <= in_data_i.du_dy;
      der_q[3] <= in_data_i.dv_dy;
      for (int i = 1; i < NST; i++) ctx_q[i] <= ctx_q[i-1];
      sq_q  <= sq_d;
      m_q   <= m_d;
      m3_q  <= m_q;
      lg_q[0] <= '0;
      lg_q[1] <= '0;
      lg_q[2] <= '0;
      lg_q[3] <= lg_d3;
      for (int i = 4; i < NST; i++) lg_q[i] <= lg_q[i-1];
      mant_q <= mant_d;
      bits_q <= bits_d;
      lo_q <= lo_d;
      t_q  <= t_d;
    end
  end

endmodule

FILE: rtl/tts_back.sv
// Sampler back part: issues texel writes and bank reads for queued jobs, filters
// across four corners, blends two levels for a fractional lod. Uses tts_pkg, tts_ram.
module tts_back #(
  parameter int unsigned MAX_SIZE_LOG2   = tts_pkg::MAX_SIZE_LOG2,
  parameter int unsigned COORD_FRAC_BITS = tts_pkg::COORD_FRAC_BITS,
  parameter int unsigned JW = tts_pkg::job_width(MAX_SIZE_LOG2, COORD_FRAC_BITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [JW-1:0]      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tts_pkg::out_item_t out_data_o
);

  localparam int unsigned M  = MAX_SIZE_LOG2;
  localparam int unsigned F  = COORD_FRAC_BITS;
  localparam int unsigned LW = tts_pkg::lvl_width(M);
  localparam int unsigned XW = tts_pkg::crd_width(M);
  localparam int unsigned BD = tts_pkg::bank_depth(M);
  localparam int unsigned AW = (BD < 2) ? 1 : $clog2(BD);
  localparam int unsigned RW = 8 + F;

  typedef struct packed {
    logic                  is_wr;
    logic [LW-1:0]         k;
    logic [7:0]            t;
    logic [31:0]           rgba;
    logic [1:0][XW-1:0]    x0, x1, y0, y1;
    logic [1:0][F-1:0]     tx, ty;
  } job_t;

  typedef struct packed {
    logic         second;
    logic [7:0]   t;
    logic [F-1:0] tx;
    logic [F-1:0] ty;
    logic         px0, px1, py0, py1;
  } b1_t;

  function automatic logic [AW-1:0] tex_addr(logic [LW-1:0] k, logic [XW-1:0] x,
                                             logic [XW-1:0] y);
    logic [AW-1:0] a;
    a = AW'(tts_pkg::bank_base(32'(k), M));
    if (32'(k) < M) a = a + (AW'(y >> 1) << (M - 1 - 32'(k))) + AW'(x >> 1);
    return a;
  endfunction

  job_t           head;
  logic           have, adv, issue_rd, phase_q, phase_d;
  logic [LW-1:0]  kk;
  logic [AW-1:0]  wa;
  logic [31:0]    rd [4];
  logic           b1_vld_q, b2_vld_q, b3_vld_q, out_vld_q;
  b1_t            b1_q;
  logic [RW-1:0]  r0_q [4], r1_q [4], r0_d [4], r1_d [4];
  logic [F-1:0]   b2_ty_q;
  logic [7:0]     b2_t_q, b3_t_q;
  logic           b2_sec_q, b3_sec_q;
  logic [7:0]     lv_d [4], lv_q [4], lo_q [4], res_d [4];
  logic           produce;
  tts_pkg::out_item_t out_q;

  assign head     = job_t'(q_job_i);
  assign have     = !q_empty_i;
  assign adv      = !out_vld_q || !out_stall_i;
  assign issue_rd = adv && have && !head.is_wr;
  assign kk       = head.k + LW'(phase_q);
  assign wa       = tex_addr(head.k, head.x0[0], head.y0[0]);
  assign q_pop_o  = adv && have && (head.is_wr || phase_q || head.t == 8'd0);

  always_comb begin
    phase_d = phase_q;
    if (adv && have && !head.is_wr) phase_d = !phase_q && (head.t != 8'd0);
  end

  // four banks split by column and row parity; distinct corners always land apart
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] xa, ya;
    logic          wsel;
    assign xa   = (head.x0[phase_q][0] == 1'(b)) ? head.x0[phase_q] : head.x1[phase_q];
    assign ya   = (head.y0[phase_q][0] == 1'(b >> 1)) ? head.y0[phase_q] : head.y1[phase_q];
    assign wsel = ({head.y0[0][0], head.x0[0][0]} == 2'(b));

    tts_ram #(
      .WIDTH (32),
      .DEPTH (BD)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (adv && have && head.is_wr && wsel),
      .waddr_i (wa),
      .wdata_i (head.rgba),
      .re_i    (issue_rd),
      .raddr_i (tex_addr(kk, xa, ya)),
      .rdata_o (rd[b])
    );
  end

  // blend along x on both rows
  always_comb begin
    logic [7:0]   c00, c10, c01, c11;
    logic [F:0]   wx, ix;
    wx = (F + 1)'(b1_q.tx);
    ix = (F + 1)'(32'd1 << F) - wx;
    for (int c = 0; c < 4; c++) begin
      c00 = rd[{b1_q.py0, b1_q.px0}][8*c +: 8];
      c10 = rd[{b1_q.py0, b1_q.px1}][8*c +: 8];
      c01 = rd[{b1_q.py1, b1_q.px0}][8*c +: 8];
      c11 = rd[{b1_q.py1, b1_q.px1}][8*c +: 8];
      r0_d[c] = RW'(RW'(c00) * RW'(ix) + RW'(c10) * RW'(wx));
      r1_d[c] = RW'(RW'(c01) * RW'(ix) + RW'(c11) * RW'(wx));
    end
  end

  // blend along y
  always_comb begin
    logic [F:0]        wy, iy;
    logic [RW+F-1:0]   r;
    wy = (F + 1)'(b2_ty_q);
    iy = (F + 1)'(32'd1 << F) - wy;
    for (int c = 0; c < 4; c++) begin
      r = (RW + F)'((RW + F)'(r0_q[c]) * (RW + F)'(iy) + (RW + F)'(r1_q[c]) * (RW + F)'(wy));
      lv_d[c] = r[2*F +: 8];
    end
  end

  // blend the two levels, or pass a single level through
  always_comb begin
    logic [15:0] bl;
    for (int c = 0; c < 4; c++) begin
      bl = 16'(16'(lo_q[c]) * (16'd256 - 16'(b3_t_q)) + 16'(lv_q[c]) * 16'(b3_t_q));
      res_d[c] = b3_sec_q ? bl[15:8] : lv_q[c];
    end
    produce = b3_vld_q && (b3_sec_q || b3_t_q == 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      phase_q   <= phase_d;
      b1_vld_q  <= issue_rd;
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= b2_vld_q;
      out_vld_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q.second <= phase_q;
      b1_q.t      <= head.t;
      b1_q.tx     <= head.tx[phase_q];
      b1_q.ty     <= head.ty[phase_q];
      b1_q.px0    <= head.x0[phase_q][0];
      b1_q.px1    <= head.x1[phase_q][0];
      b1_q.py0    <= head.y0[phase_q][0];
      b1_q.py1    <= head.y1[phase_q][0];
      r0_q     <= r0_d;
      r1_q     <= r1_d;
      b2_ty_q  <= b1_q.ty;
      b2_t_q   <= b1_q.t;
      b2_sec_q <= b1_q.second;
      lv_q     <= lv_d;
      b3_t_q   <= b2_t_q;
      b3_sec_q <= b2_sec_q;
      // hold the lower level until its partner arrives
      if (b3_vld_q && !b3_sec_q && b3_t_q != 8'd0) lo_q <= lv_q;
      if (produce) out_q <= '{red: res_d[0], green: res_d[1], blue: res_d[2],
                              alpha: res_d[3]};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/sv/trilinear_texture_sampler_tb.sv
// Self-checking testbench for trilinear_texture_sampler: texel writes and filtered samples
// against a behavioural predictor, with random idling on both channels.
// Depends on tts_pkg and the RTL top level.
module trilinear_texture_sampler_tb;

  localparam int unsigned STORE_DEPTH = 87381;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  tts_pkg::in_item_t   in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  tts_pkg::out_item_t  out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [3:0]          cfg_data_i;

  trilinear_texture_sampler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  logic [31:0]        texel_mem [STORE_DEPTH];
  bit                 texel_known [STORE_DEPTH];
  int unsigned        chain_log2;
  tts_pkg::in_item_t  pending_beats [$];
  tts_pkg::out_item_t colour_expected [$];
  int                 mismatches;
  bit                 steady;
  bit                 recv_block;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned texel_index(int unsigned k, int unsigned x, int unsigned y);
    int unsigned b;
    b = 0;
    for (int unsigned j = 0; j < k; j++) b += 1 << (2 * (tts_pkg::MAX_SIZE_LOG2 - j));
    return b + y * (1 << (tts_pkg::MAX_SIZE_LOG2 - k)) + x;
  endfunction

  // log2 with 9 fraction bits by repeated squaring of the mantissa
  function automatic int unsigned log2_q9(longint unsigned n);
    int unsigned e;
    int unsigned bits;
    longint unsigned m;
    e = 0;
    bits = 0;
    while (e < 63 && (n >> (e + 1)) != 0) e++;
    m = (e > 31) ? (n >> (e - 31)) : (n << (31 - e));
    for (int i = 0; i < 9; i++) begin
      m = (m * m) >> 31;
      bits = bits << 1;
      if (m >= 64'h1_0000_0000) begin
        bits = bits | 1;
        m = m >> 1;
      end
    end
    return (e << 9) | bits;
  endfunction

  function automatic longint unsigned sq_len(logic signed [23:0] a, logic signed [23:0] b);
    longint sa;
    longint sb;
    sa = a;
    sb = b;
    if (sa < 0) sa = -sa;
    if (sb < 0) sb = -sb;
    return sa * sa + sb * sb;
  endfunction

  // bilinear filter of one level; clears ok when a corner was never written
  function automatic void bilinear(int unsigned k, longint unsigned fu, longint unsigned fv,
                                   inout bit ok, output logic [7:0] ch [4]);
    int unsigned side;
    longint unsigned xs;
    longint unsigned ys;
    longint unsigned tx;
    longint unsigned ty;
    longint unsigned r0;
    longint unsigned r1;
    int unsigned x0, x1, y0, y1;
    int unsigned ix [4];
    logic [31:0] t [4];
    side = 1 << (chain_log2 - k);
    xs = fu * (side - 1);
    ys = fv * (side - 1);
    x0 = 32'(xs >> 16);
    y0 = 32'(ys >> 16);
    x1 = (x0 + 1 > side - 1) ? side - 1 : x0 + 1;
    y1 = (y0 + 1 > side - 1) ? side - 1 : y0 + 1;
    tx = xs & 16'hFFFF;
    ty = ys & 16'hFFFF;
    ix[0] = texel_index(k, x0, y0);
    ix[1] = texel_index(k, x1, y0);
    ix[2] = texel_index(k, x0, y1);
    ix[3] = texel_index(k, x1, y1);
    for (int i = 0; i < 4; i++) begin
      if (!texel_known[ix[i]]) ok = 1'b0;
      t[i] = texel_mem[ix[i]];
    end
    for (int c = 0; c < 4; c++) begin
      r0 = t[0][8*c +: 8] * (65536 - tx) + t[1][8*c +: 8] * tx;
      r1 = t[2][8*c +: 8] * (65536 - tx) + t[3][8*c +: 8] * tx;
      ch[c] = 8'((r0 * (65536 - ty) + r1 * ty) >> 32);
    end
  endfunction

  function automatic tts_pkg::out_item_t filtered_colour(tts_pkg::in_item_t it, output bit ok);
    longint unsigned lx;
    longint unsigned ly;
    longint unsigned m;
    int lod8;
    int v;
    int unsigned lo;
    int unsigned t;
    logic [7:0] a [4];
    logic [7:0] b [4];
    tts_pkg::out_item_t res;
    ok = 1'b1;
    lx = sq_len(it.du_dx, it.dv_dx);
    ly = sq_len(it.du_dy, it.dv_dy);
    m = (lx > ly) ? lx : ly;
    lod8 = 0;
    if (m != 0) begin
      v = int'(log2_q9(m)) + int'((2 * chain_log2) << 9) - (32 << 9);
      if (v > 0) lod8 = v >>> 1;
    end
    if (lod8 > int'(chain_log2 << 8)) lod8 = int'(chain_log2 << 8);
    lo = lod8 >> 8;
    t = lod8 & 8'hFF;
    bilinear(lo, it.u_coord[15:0], it.v_coord[15:0], ok, a);
    if (t != 0) begin
      bilinear(lo + 1, it.u_coord[15:0], it.v_coord[15:0], ok, b);
      for (int c = 0; c < 4; c++) a[c] = 8'((a[c] * (256 - t) + b[c] * t) >> 8);
    end
    res.red = a[0];
    res.green = a[1];
    res.blue = a[2];
    res.alpha = a[3];
    return res;
  endfunction

  function automatic bit in_chain(tts_pkg::in_item_t it);
    return it.level <= chain_log2 && it.texel_x < (1 << (chain_log2 - it.level))
           && it.texel_y < (1 << (chain_log2 - it.level));
  endfunction

  // queue a texel write; in-chain entries become readable for later samples
  function automatic void queue_write(int unsigned k, int unsigned x, int unsigned y,
                                      logic [31:0] rgba);
    tts_pkg::in_item_t it;
    it = tts_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.mode = tts_pkg::MODE_WRITE;
    it.level = 4'(k);
    it.texel_x = 8'(x);
    it.texel_y = 8'(y);
    it.texel_rgba = rgba;
    if (in_chain(it)) texel_known[texel_index(k, x, y)] = 1'b1;
    pending_beats.push_back(it);
  endfunction

  function automatic logic signed [23:0] rand_deriv();
    logic signed [23:0] d;
    d = 24'($urandom >> $urandom_range(8, 31));
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  // queue a sample; up to 30 retries with new derivatives to read only written texels
  function automatic void queue_sample(tts_pkg::in_item_t it, bit reroll);
    bit ok;
    tts_pkg::out_item_t dummy;
    it.mode = tts_pkg::MODE_SAMPLE;
    for (int i = 0; i < 30; i++) begin
      dummy = filtered_colour(it, ok);
      if (ok) break;
      if (!reroll) it.u_coord = 24'($urandom);
      it.du_dx = rand_deriv();
      it.dv_dx = rand_deriv();
      it.du_dy = rand_deriv();
      it.dv_dy = rand_deriv();
    end
    dummy = filtered_colour(it, ok);
    if (!ok) it.du_dx = 24'sh7FFFFF;
    pending_beats.push_back(it);
  endfunction

  // driver: present queued beats, draw a gap after each one
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    bit ok;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.mode == tts_pkg::MODE_SAMPLE)
          colour_expected.push_back(filtered_colour(in_data_i, ok));
        else if (in_chain(in_data_i))
          texel_mem[texel_index(in_data_i.level, in_data_i.texel_x, in_data_i.texel_y)] =
            in_data_i.texel_rgba;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          send_gap = steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat against the oldest expected colour
  int unsigned recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    tts_pkg::out_item_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (recv_gap > 0 && !recv_block) recv_gap--;
      if (out_valid_o && !out_stall_i) begin
        if (colour_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          exp_c = colour_expected.pop_front();
          if (exp_c.red !== out_data_o.red || exp_c.green !== out_data_o.green ||
              exp_c.blue !== out_data_o.blue || exp_c.alpha !== out_data_o.alpha) begin
            mismatches++;
            if (mismatches <= 10)
              $display("colour mismatch: expected %h, got %h", exp_c, out_data_o);
          end
        end
        recv_gap = steady ? 0 : $urandom_range(0, 3);
      end
      out_stall_i <= recv_block || recv_gap > 0;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid_i || colour_expected.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [3:0] size_cfg, int n_rand, bit squeeze);
    tts_pkg::in_item_t it;
    int unsigned side;
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size_cfg;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    chain_log2 = (size_cfg > tts_pkg::MAX_SIZE_LOG2) ? tts_pkg::MAX_SIZE_LOG2 : size_cfg;
    steady = ($urandom_range(0, 3) == 0);
    // fill the small levels so that most samples have something to read
    for (int k = chain_log2; k >= 0; k--) begin
      side = 1 << (chain_log2 - k);
      if (side <= 8)
        for (int y = 0; y < side; y++)
          for (int x = 0; x < side; x++) queue_write(k, x, y, $urandom);
    end
    queue_write(chain_log2, 0, 0, 32'hFFFF_FFFF);
    queue_write(15, 255, 255, $urandom);
    queue_write(0, 255, 255, 32'h0000_0000);
    it = '0;
    queue_sample(it, 1'b1);                          // zero footprint
    it.u_coord = 24'sh800000;
    it.v_coord = 24'sh7FFFFF;
    it.du_dx = 24'sh800000;
    it.dv_dy = 24'sh800000;
    queue_sample(it, 1'b1);                          // extreme coordinates and derivatives
    it = '0;
    it.u_coord = 24'sh00FFFF;
    it.v_coord = 24'sh008000;
    it.du_dx = 24'sd1 << (17 - chain_log2);          // integer lod
    queue_sample(it, 1'b1);
    it.du_dx = 24'sd3;                               // footprint below one texel
    it.dv_dy = -24'sd5;
    queue_sample(it, 1'b1);
    for (int i = 0; i < n_rand; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        it = tts_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom});
        it.du_dx = rand_deriv();
        it.dv_dx = rand_deriv();
        it.du_dy = rand_deriv();
        it.dv_dy = rand_deriv();
        queue_sample(it, 1'b0);
      end else if ($urandom_range(0, 4) == 0) begin
        queue_write($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom);
      end else begin
        it.level = 4'($urandom_range(0, chain_log2));
        side = 1 << (chain_log2 - it.level);
        queue_write(it.level, $urandom_range(0, side - 1), $urandom_range(0, side - 1),
                    $urandom);
      end
    end
    if (squeeze) begin
      // hold the output off so the queue fills and the input stalls
      recv_block <= 1'b1;
      repeat (400) @(posedge clk_i);
      recv_block <= 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    recv_block = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    chain_log2 = tts_pkg::MAX_SIZE_LOG2;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(4'd8, 200, 1'b0);
    run_phase(4'd0, 100, 1'b1);
    run_phase(4'd2, 150, 1'b0);
    run_phase(4'd3, 150, 1'b1);
    run_phase(4'd15, 200, 1'b0);
    run_phase(4'd1, 100, 1'b0);
    run_phase(4'd5, 150, 1'b0);
    run_phase(4'd8, 200, 1'b0);
    wait_idle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && colour_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
